### rtl/fba_pkg.sv
`default_nettype none

package fba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W     = 16;
  localparam int CFG_W      = 5;

  // register indexes
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // placement policies (code 3 behaves as first fit)
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

### rtl/fit_block_allocator.sv
`default_nettype none
// First / best / worst fit allocator over a table of 16 free-space counts.
//
// Input channel (in_valid / in_stall): one transaction is either a load
// (in_operation = 0, writes in_block_size into entry in_block_index) or an
// allocate (in_operation = 1, asks for in_request_size).
// Output channel (out_valid / out_stall): exactly one result transaction per
// input transaction, in order: granted flag, chosen block, size left.
// Config port: cfg_write_en with cfg_index 0 = fit_mode, 1 = block_count.
// Write it only while the block is idle with no result outstanding.
//
// Steps: a load goes through ST_DONE to the result reg; an allocate runs
// N scan steps, N = min(block_count, 16), one compare per cycle (first fit
// stops at its hit), then end of scan, write-back and the result reg.
// One transaction is in flight at a time and in_stall is high while it works:
// a new input is taken only after the last one has left ST_DONE.
// The result register holds a finished result while out_stall is high; a
// new input may be accepted meanwhile, and its result waits in ST_DONE.
// Reset (rst_n low, synchronous) clears the sequencer, out_valid and the
// config registers; the free-space table is undefined until loaded.

module fit_block_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_operation,
  input  wire logic [3:0]                  in_block_index,
  input  wire logic [15:0]                 in_block_size,
  input  wire logic [15:0]                 in_request_size,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_granted,
  output logic [3:0]                       out_chosen_block,
  output logic [15:0]                      out_size_left,
  input  wire logic                        cfg_write_en,
  input  wire logic                        cfg_index,
  input  wire logic [fba_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IDX_W  = fba_pkg::IDX_W;
  localparam int CNT_W  = fba_pkg::CNT_W;
  localparam int SIZE_W = fba_pkg::SIZE_W;

  // Free-space table
  logic [SIZE_W-1:0] free_space_r [fba_pkg::MAX_BLOCKS];

  // Configuration
  logic [1:0]       fit_mode_r;
  logic [4:0]       block_count_r;

  // Sequencer and scan state
  fba_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [SIZE_W-1:0] best_r, best_nxt;

  // Pending result
  logic             res_granted_r, res_granted_nxt;
  logic [IDX_W-1:0] res_block_r, res_block_nxt;
  logic [SIZE_W-1:0] res_size_r, res_size_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_granted_r;
  logic [3:0]       out_block_r;
  logic [SIZE_W-1:0] out_size_r;

  logic             in_accept;
  logic             out_load;
  logic             tab_we;
  logic [IDX_W-1:0] tab_waddr;
  logic [SIZE_W-1:0] tab_wdata;

  // Shared scan unit: one table read, one fit compare, one rank compare
  logic [SIZE_W-1:0] scan_size;
  logic              scan_fits;
  logic              scan_better;
  logic              scan_end;
  logic              mode_first;
  logic [SIZE_W-1:0] size_after;

  assign in_stall  = (state_r != fba_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == fba_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  assign mode_first  = (fit_mode_r != fba_pkg::MODE_BEST) &&
                       (fit_mode_r != fba_pkg::MODE_WORST);
  assign scan_end    = (cnt_r >= used_r);
  assign scan_size   = free_space_r[cnt_r[IDX_W-1:0]];
  assign scan_fits   = (scan_size >= req_r);
  assign scan_better = (fit_mode_r == fba_pkg::MODE_BEST)  ? (scan_size < best_r) :
                       (fit_mode_r == fba_pkg::MODE_WORST) ? (scan_size > best_r) :
                       1'b0;
  assign size_after  = best_r - req_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    used_nxt        = used_r;
    req_nxt         = req_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    best_nxt        = best_r;
    res_granted_nxt = res_granted_r;
    res_block_nxt   = res_block_r;
    res_size_nxt    = res_size_r;
    tab_we          = 1'b0;
    tab_waddr       = pick_r;
    tab_wdata       = size_after;

    case (state_r)
      fba_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_operation == fba_pkg::OP_LOAD) begin
            // every 4-bit index lies inside the table
            tab_we          = 1'b1;
            tab_waddr       = in_block_index;
            tab_wdata       = in_block_size;
            res_granted_nxt = 1'b1;
            res_block_nxt   = in_block_index;
            res_size_nxt    = in_block_size;
            state_nxt       = fba_pkg::ST_DONE;
          end else begin
            req_nxt   = in_request_size;
            used_nxt  = (block_count_r > 5'(fba_pkg::MAX_BLOCKS)) ?
                        CNT_W'(fba_pkg::MAX_BLOCKS) : CNT_W'(block_count_r);
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            pick_nxt  = '0;
            best_nxt  = '0;
            state_nxt = fba_pkg::ST_SCAN;
          end
        end
      end
      fba_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = fba_pkg::ST_UPD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (scan_fits && !found_r) begin
            found_nxt = 1'b1;
            pick_nxt  = cnt_r[IDX_W-1:0];
            best_nxt  = scan_size;
            if (mode_first) begin
              state_nxt = fba_pkg::ST_UPD;
            end
          end else if (scan_fits && scan_better) begin
            pick_nxt = cnt_r[IDX_W-1:0];
            best_nxt = scan_size;
          end
        end
      end
      fba_pkg::ST_UPD: begin
        if (found_r) begin
          tab_we          = 1'b1;
          res_granted_nxt = 1'b1;
          res_block_nxt   = pick_r;
          res_size_nxt    = size_after;
        end else begin
          res_granted_nxt = 1'b0;
          res_block_nxt   = '0;
          res_size_nxt    = '0;
        end
        state_nxt = fba_pkg::ST_DONE;
      end
      fba_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = fba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fba_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      fit_mode_r    <= fba_pkg::MODE_FIRST;
      block_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en && (cfg_index == fba_pkg::CFG_FIT_MODE)) begin
        fit_mode_r <= cfg_data[1:0];
      end
      if (cfg_write_en && (cfg_index == fba_pkg::CFG_BLOCK_COUNT)) begin
        block_count_r <= cfg_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    used_r        <= used_nxt;
    req_r         <= req_nxt;
    found_r       <= found_nxt;
    pick_r        <= pick_nxt;
    best_r        <= best_nxt;
    res_granted_r <= res_granted_nxt;
    res_block_r   <= res_block_nxt;
    res_size_r    <= res_size_nxt;
    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_block_r   <= res_block_r;
      out_size_r    <= res_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      free_space_r[tab_waddr] <= tab_wdata;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_block_r;
  assign out_size_left    = out_size_r;

  // scan pointer never runs past the clamped count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fba_pkg::ST_SCAN) |-> (cnt_r <= used_r))
    else $error("scan pointer past block count");

  // a hit always lies inside the scanned range
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fba_pkg::ST_UPD && found_r) |-> (CNT_W'(pick_r) < used_r))
    else $error("chosen block outside range");

  // a refused result carries zeros
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fba_pkg::ST_DONE && !res_granted_r) |->
      (res_block_r == '0 && res_size_r == '0))
    else $error("refused result not zero");

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != fba_pkg::ST_IDLE))
    else $error("accepted transaction dropped");

endmodule

`default_nettype wire

### sim/fit_block_allocator_test.sv
`timescale 1ns / 1ps

module fit_block_allocator_test;

  // One input transaction: a load or an allocate, laid out as the port fields.
  typedef struct packed {
    logic                       op;
    logic [fba_pkg::IDX_W-1:0]  idx;
    logic [fba_pkg::SIZE_W-1:0] bsize;
    logic [fba_pkg::SIZE_W-1:0] req;
  } alloc_req_t;

  // One result transaction.
  typedef struct packed {
    logic                       granted;
    logic [fba_pkg::IDX_W-1:0]  blk;
    logic [fba_pkg::SIZE_W-1:0] left;
  } grant_t;

  localparam int PHASES     = 12;
  localparam int PHASE_OPS  = 125;
  // Margin after the last result before touching the registers.
  localparam int SETTLE_CYC = 24;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_operation = fba_pkg::OP_LOAD;
  logic [3:0]                in_block_index = '0;
  logic [15:0]               in_block_size = '0;
  logic [15:0]               in_request_size = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_granted;
  logic [3:0]                out_chosen_block;
  logic [15:0]               out_size_left;
  logic                      cfg_write_en = 1'b0;
  logic                      cfg_index = fba_pkg::CFG_FIT_MODE;
  logic [fba_pkg::CFG_W-1:0] cfg_data = '0;

  // Our own view of the block: free-space table and register copies.
  logic [fba_pkg::SIZE_W-1:0] free_left [fba_pkg::MAX_BLOCKS];
  logic [1:0]                 policy = fba_pkg::MODE_FIRST;
  logic [fba_pkg::CFG_W-1:0]  blocks_in_use = '0;

  alloc_req_t        queued_ops [$];   // transactions not yet presented
  grant_t            owed_grants [$];  // predicted results, oldest first
  alloc_req_t        next_op;
  grant_t            want;

  int                send_hold = 0;
  int                recv_hold = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                errors = 0;
  int                n_loads = 0;
  int                n_granted = 0;
  int                n_refused = 0;
  int                n_settings = 0;

  fit_block_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_block_index   (in_block_index),
    .in_block_size    (in_block_size),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_size_left    (out_size_left),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // Placement predictor. Applies one accepted transaction to the local table
  // and returns the result the block must produce for it.
  function automatic grant_t place_request(alloc_req_t r);
    grant_t g;
    int     span;
    int     pick;
    g    = '0;
    pick = -1;
    if (r.op == fba_pkg::OP_LOAD) begin
      // every 4-bit index is inside the table, so a load always lands
      free_left[r.idx] = r.bsize;
      g.granted = 1'b1;
      g.blk     = r.idx;
      g.left    = r.bsize;
      n_loads++;
      return g;
    end
    span = (blocks_in_use > fba_pkg::MAX_BLOCKS) ? fba_pkg::MAX_BLOCKS
                                                  : int'(blocks_in_use);
    for (int i = 0; i < span; i++) begin
      if (free_left[i] >= r.req) begin
        // first hit wins unless the policy keeps looking; strict compares
        // keep ties on the lowest index, and mode 3 falls to first fit
        if (pick < 0)
          pick = i;
        else if (policy == fba_pkg::MODE_BEST && free_left[i] < free_left[pick])
          pick = i;
        else if (policy == fba_pkg::MODE_WORST && free_left[i] > free_left[pick])
          pick = i;
      end
    end
    if (pick < 0) begin
      n_refused++;
      return g;
    end
    free_left[pick] = free_left[pick] - r.req;
    g.granted = 1'b1;
    g.blk     = fba_pkg::IDX_W'(pick);
    g.left    = free_left[pick];
    n_granted++;
    return g;
  endfunction

  // Random transaction. Loads keep refilling the table; sizes lean toward
  // repeated multiples of 512 so best/worst fit see plenty of ties.
  function automatic alloc_req_t random_op();
    alloc_req_t r;
    int         sel;
    r.op    = ($urandom_range(99) < 25) ? fba_pkg::OP_LOAD : fba_pkg::OP_ALLOC;
    r.idx   = fba_pkg::IDX_W'($urandom_range(fba_pkg::MAX_BLOCKS - 1));
    r.bsize = fba_pkg::SIZE_W'($urandom);
    r.req   = fba_pkg::SIZE_W'($urandom);
    sel     = $urandom_range(9);
    if (r.op == fba_pkg::OP_LOAD) begin
      case (sel)
        4, 5, 6: r.bsize = fba_pkg::SIZE_W'($urandom_range(1, 8) * 512);
        7:       r.bsize = '0;
        8:       r.bsize = '1;
        9:       r.bsize = fba_pkg::SIZE_W'($urandom_range(255));
        default: ;
      endcase
    end else begin
      case (sel)
        0:          r.req = '0;
        1:          ;
        2:          r.req = '1;
        3, 4, 5, 6: r.req = fba_pkg::SIZE_W'($urandom_range(1, 255));
        default:    r.req = fba_pkg::SIZE_W'($urandom_range(256, 4095));
      endcase
    end
    return r;
  endfunction

  function automatic alloc_req_t load_op(int idx, int size);
    return '{op: fba_pkg::OP_LOAD, idx: fba_pkg::IDX_W'(idx),
             bsize: fba_pkg::SIZE_W'(size), req: '0};
  endfunction

  function automatic alloc_req_t alloc_op(int size);
    return '{op: fba_pkg::OP_ALLOC, idx: '0, bsize: '0,
             req: fba_pkg::SIZE_W'(size)};
  endfunction

  // Register writes, fit mode and then block count, back to back. Only called while
  // the block is idle, so updating the local copies here is safe.
  task automatic write_settings(logic [1:0] mode, logic [fba_pkg::CFG_W-1:0] count);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= fba_pkg::CFG_FIT_MODE;
    cfg_data     <= fba_pkg::CFG_W'(mode);
    policy        = mode;
    @(posedge clk);
    cfg_index    <= fba_pkg::CFG_BLOCK_COUNT;
    cfg_data     <= count;
    blocks_in_use = count;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    n_settings++;
  endtask

  // Wait until every queued transaction is accepted and answered. Checked on
  // the falling edge so all rising-edge updates have landed.
  task automatic settle();
    do
      @(negedge clk);
    while (queued_ops.size() != 0 || in_valid || owed_grants.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Driver: presents queued transactions, holds them while stalled, and
  // inserts idle bursts between transactions.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_hold <= 0;
    end else begin
      if (in_valid && !in_stall)
        owed_grants.push_back(place_request(
          {in_operation, in_block_index, in_block_size, in_request_size}));
      if (!in_valid || !in_stall) begin
        if (send_hold > 0) begin
          send_hold <= send_hold - 1;
          in_valid  <= 1'b0;
        end else if (queued_ops.size() != 0) begin
          next_op          = queued_ops.pop_front();
          in_valid        <= 1'b1;
          in_operation    <= next_op.op;
          in_block_index  <= next_op.idx;
          in_block_size   <= next_op.bsize;
          in_request_size <= next_op.req;
          if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            send_hold <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  // and drives result-side stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_grants.size() == 0) begin
          $display("%0t: result with nothing pending: granted %0d block %0d left %0d",
                   $time, out_granted, out_chosen_block, out_size_left);
          errors++;
        end else begin
          want = owed_grants.pop_front();
          if (out_granted !== want.granted) begin
            $display("%0t: granted expected %0d actual %0d",
                     $time, want.granted, out_granted);
            errors++;
          end
          if (out_chosen_block !== want.blk) begin
            $display("%0t: chosen_block expected %0d actual %0d",
                     $time, want.blk, out_chosen_block);
            errors++;
          end
          if (out_size_left !== want.left) begin
            $display("%0t: size_left expected %0d actual %0d",
                     $time, want.left, out_size_left);
            errors++;
          end
        end
      end
      if (recv_hold > 0) begin
        out_stall <= 1'b1;
        recv_hold <= recv_hold - 1;
      end else begin
        out_stall <= 1'b0;
        if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
          recv_hold <= $urandom_range(1, 19);
      end
    end
  end

  // Stimulus and phase sequencing.
  initial begin
    int unsigned load_sizes [fba_pkg::MAX_BLOCKS] = '{300, 0, 65535, 300, 1000, 1000,
                                                      40000, 40000, 7, 12, 65535,
                                                      2048, 100, 5000, 9, 300};
    int unsigned count_plan [PHASES] = '{16, 16, 8, 31, 1, 0, 16, 17, 12, 16, 4, 16};
    int          idle_plan [4] = '{0, 15, 35, 60};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every entry loaded before any allocate so no scan ever reads
    // an unwritten entry. Reset leaves block_count at zero: refused.
    send_idle_pct = 30;
    recv_idle_pct = 30;
    for (int i = 0; i < fba_pkg::MAX_BLOCKS; i++)
      queued_ops.push_back(load_op(i, load_sizes[i]));
    queued_ops.push_back(alloc_op(0));
    settle();

    // Best fit over the full table: zero request takes the empty entry,
    // equal sizes resolve to the lower index, the last 65535 is refused.
    write_settings(fba_pkg::MODE_BEST, 5'd16);
    queued_ops.push_back(alloc_op(0));
    queued_ops.push_back(alloc_op(300));
    queued_ops.push_back(alloc_op(65535));
    queued_ops.push_back(alloc_op(65535));
    queued_ops.push_back(alloc_op(65535));
    settle();

    // Worst fit with an out-of-range count (saturates to the full table).
    write_settings(fba_pkg::MODE_WORST, 5'd31);
    queued_ops.push_back(alloc_op(1));
    queued_ops.push_back(alloc_op(39999));
    settle();

    // Policy code 3 acts as first fit.
    write_settings(2'd3, 5'd17);
    queued_ops.push_back(alloc_op(5));
    settle();

    // Single block in use, now empty: refused.
    write_settings(fba_pkg::MODE_FIRST, 5'd1);
    queued_ops.push_back(alloc_op(1));
    settle();

    // Random phases. Each ends fully drained (sender pauses until every
    // result is back) before the registers change. The last two run with
    // no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      write_settings(2'(p % 4), fba_pkg::CFG_W'(count_plan[p]));
      if (p >= PHASES - 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = idle_plan[p % 4];
        recv_idle_pct = idle_plan[$urandom_range(3)];
      end
      for (int k = 0; k < PHASE_OPS; k++)
        queued_ops.push_back(random_op());
      settle();
    end

    $display("Covered %0d loads and %0d allocations (%0d granted, %0d refused)",
             n_loads, n_granted + n_refused, n_granted, n_refused);
    $display("over %0d register settings, all four policy codes, counts 0 to 31.",
             n_settings);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: ends the run as a failure if it hangs.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
